### design/ebd_pkg.sv
// Shared types and constants of the energy beat detector.
// Used by ebd_div, ebd_ring and energy_beat_detector; depends on nothing.
`default_nettype none

package ebd_pkg;

  // History depth and derived widths
  localparam int HISTORY_DEPTH = 32;
  localparam int RING_AW       = $clog2(HISTORY_DEPTH);
  localparam int ENERGY_W      = 16;
  localparam int TOTAL_W       = ENERGY_W + RING_AW;
  localparam int THR_W         = 21 + RING_AW;
  localparam int THR_LHS_K     = 10 * HISTORY_DEPTH;
  localparam int THR_RHS_K     = 14;
  localparam int THR_RHS_C     = 16384 * HISTORY_DEPTH;

  // Field widths
  localparam int TIME_W     = 32;
  localparam int FRAME_W    = 16;
  localparam int DT_W       = 10;
  localparam int IVL_W      = 11;
  localparam int SUM_W      = 15;
  localparam int TALLY_W    = 3;
  localparam int BPM_W      = SUM_W - TALLY_W;
  localparam int LEVEL_W    = 16;
  localparam int PHASE_W    = 16;
  localparam int FRAC_W     = 15;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_USED_W = 1 + BPM_W + LEVEL_W + PHASE_W;

  // Timing and scaling constants
  localparam int DT_DEFAULT   = 50;
  localparam int DT_MAX       = 1000;
  localparam int REFRACT_MS   = 200;
  localparam int TEMPO_MIN_MS = 250;
  localparam int TEMPO_MAX_MS = 2000;
  localparam int TEMPO_NUM    = 960000;
  localparam int AVG_LEN      = 8;
  localparam int ENV_SPAN     = 300;
  localparam int UNITY        = 32768;

  // Envelope decay divides by 300 through ceil(2^33 / 300); the floor is exact
  // for every product below 2^24, and env * (300 - dt) stays below that
  localparam int DECAY_W      = LEVEL_W + DT_W;
  localparam int ENV_RECIP    = 28633116;
  localparam int ENV_RECIP_W  = 25;
  localparam int ENV_RECIP_SH = 33;
  localparam int SCALED_W     = DECAY_W + ENV_RECIP_W;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_SYNC_ENABLE = '0;

  // Shared divider
  localparam int DIV_NW = 26;
  localparam int DIV_DW = 11;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_TEMPO_WAIT,
    S_ENV,
    S_ENV_WAIT,
    S_PHASE,
    S_PHASE_WAIT,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

### design/ebd_div.sv
// Restoring divider shared by the tempo and phase steps.
// One quotient bit per cycle; uses ebd_pkg for widths and request types.
`default_nettype none

module ebd_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ebd_pkg::div_req_t req_i,
  output ebd_pkg::div_rsp_t      rsp_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [ebd_pkg::DIV_CW-1:0] cnt_q, cnt_d;
  logic [ebd_pkg::DIV_NW-1:0] quo_q, quo_d;
  logic [ebd_pkg::DIV_DW-1:0] rem_q, rem_d;
  logic [ebd_pkg::DIV_DW-1:0] den_q, den_d;
  logic [ebd_pkg::DIV_DW:0]   trial;
  logic [ebd_pkg::DIV_DW:0]   diff;
  logic                       qbit;

  always_comb begin
    trial  = {rem_q, quo_q[ebd_pkg::DIV_NW-1]};
    diff   = trial - {1'b0, den_q};
    qbit   = (trial >= {1'b0, den_q});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = ebd_pkg::DIV_CW'(ebd_pkg::DIV_NW);
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      rem_d = qbit ? diff[ebd_pkg::DIV_DW-1:0] : trial[ebd_pkg::DIV_DW-1:0];
      quo_d = {quo_q[ebd_pkg::DIV_NW-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ebd_pkg::DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

### design/ebd_ring.sv
// Energy history ring with its running sum and per-entry valid bits.
// Uses ebd_pkg for depth and widths.
`default_nettype none

module ebd_ring (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         commit_i,
  input  wire logic [ebd_pkg::ENERGY_W-1:0] energy_i,
  output logic      [ebd_pkg::TOTAL_W-1:0]  total_o
);

  logic [ebd_pkg::ENERGY_W-1:0] mem_q [ebd_pkg::HISTORY_DEPTH];
  logic [ebd_pkg::HISTORY_DEPTH-1:0] valid_q;
  logic [ebd_pkg::RING_AW-1:0]  pos_q, pos_d;
  logic [ebd_pkg::TOTAL_W-1:0]  total_q;
  logic [ebd_pkg::ENERGY_W-1:0] rdata_q;
  logic                         rvalid_q;
  logic [ebd_pkg::ENERGY_W-1:0] old_energy;

  // Unwritten entries read as zero
  assign old_energy = rvalid_q ? rdata_q : '0;
  assign total_o    = total_q - ebd_pkg::TOTAL_W'(old_energy)
                    + ebd_pkg::TOTAL_W'(energy_i);

  always_comb begin
    if (pos_q == ebd_pkg::RING_AW'(ebd_pkg::HISTORY_DEPTH - 1)) begin
      pos_d = '0;
    end else begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      pos_q    <= '0;
      total_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[pos_q];
      if (commit_i) begin
        valid_q[pos_q] <= 1'b1;
        pos_q          <= pos_d;
        total_q        <= total_o;
      end
    end
  end

  // Read the entry at the write pointer every cycle; it is ready before the next commit
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[pos_q];
    if (commit_i) begin
      mem_q[pos_q] <= energy_i;
    end
  end

endmodule

`default_nettype wire

### design/energy_beat_detector.sv
// Energy beat detector: tempo, envelope and phase from per-frame low-band energy.
// Instantiates ebd_ring and ebd_div; uses ebd_pkg.
//
// Each frame request carries low_energy, now_ms and frame_ms and yields exactly one
// result (beat, bpm_x16, beat_level, beat_phase). A frame passes through the states
// IDLE, EVAL, ENV, PHASE and DONE, with ENV_WAIT when the envelope decays and a wait
// state when it needs a division: the single restoring divider serves the tempo term and
// the beat phase, and a frame needs at most one of them (the tempo term only on a
// beat, the phase division only without one). The envelope decay is a registered
// product and then a multiply by a constant reciprocal. s_axis_tready is high only while the
// sequencer is idle; a finished result waits in the output register without
// holding off the next request, which then holds in its last cycle until the
// register is free. The history starts all zero after reset, with no clearing
// pass. sync_enable lives at byte address 0 of the APB port.
`default_nettype none

module energy_beat_detector (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Frame requests
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [15:0] low_energy, [47:16] now_ms, [63:48] frame_ms
  input  wire logic [ebd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Results
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [0] beat, [12:1] bpm_x16, [28:13] beat_level, [44:29] beat_phase, [47:45] zero
  output logic      [ebd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [ebd_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [ebd_pkg::PDATA_W-1:0]    pwdata,
  output logic      [ebd_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready
);

  ebd_pkg::state_e state_q, state_d;

  logic [ebd_pkg::ENERGY_W-1:0] energy_q, energy_d;
  logic [ebd_pkg::TIME_W-1:0]   now_q, now_d;
  logic [ebd_pkg::DT_W-1:0]     dt_q, dt_d;
  logic                         beat_q, beat_d;
  logic [ebd_pkg::IVL_W-1:0]    since_q, since_d;
  logic [ebd_pkg::TIME_W-1:0]   prev_beat_q, prev_beat_d;
  logic                         prev_valid_q, prev_valid_d;
  logic [ebd_pkg::SUM_W-1:0]    tempo_sum_q, tempo_sum_d;
  logic [ebd_pkg::TALLY_W-1:0]  tempo_tally_q, tempo_tally_d;
  logic [ebd_pkg::BPM_W-1:0]    tempo_avg_q, tempo_avg_d;
  logic [ebd_pkg::IVL_W-1:0]    latched_q, latched_d;
  logic [ebd_pkg::LEVEL_W-1:0]  env_q, env_d;
  logic [ebd_pkg::DECAY_W-1:0]  decay_q, decay_d;
  logic [ebd_pkg::TIME_W-1:0]   anchor_q, anchor_d;
  logic [ebd_pkg::PHASE_W-1:0]  phase_q, phase_d;
  logic                         sync_q;
  logic                         m_valid_q, m_valid_d;
  logic [ebd_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;

  logic                          ring_commit;
  logic [ebd_pkg::TOTAL_W-1:0]   ring_total;
  ebd_pkg::div_req_t             div_req;
  ebd_pkg::div_rsp_t             div_rsp;

  logic [ebd_pkg::FRAME_W-1:0]   frame;
  logic [ebd_pkg::TIME_W-1:0]    since;
  logic [ebd_pkg::TIME_W-1:0]    elapsed;
  logic [ebd_pkg::THR_W-1:0]     thr_lhs;
  logic [ebd_pkg::THR_W-1:0]     thr_rhs;
  logic                          beat_now;
  logic                          tempo_ok;
  logic [ebd_pkg::SUM_W-1:0]     sum_new;
  logic [ebd_pkg::SUM_W:0]       sum_round;
  logic [ebd_pkg::DT_W-1:0]      env_scale;
  logic [ebd_pkg::SCALED_W-1:0]  decay_scaled;
  logic                          tracking;
  logic                          cfg_wr;

  ebd_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .commit_i (ring_commit),
    .energy_i (energy_q),
    .total_o  (ring_total)
  );

  ebd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                && (paddr[ebd_pkg::PADDR_W-1:2] == ebd_pkg::REG_SYNC_ENABLE);
  assign prdata = (paddr[ebd_pkg::PADDR_W-1:2] == ebd_pkg::REG_SYNC_ENABLE)
                ? {{(ebd_pkg::PDATA_W-1){1'b0}}, sync_q} : '0;

  // Datapath terms shared by the sequencer
  assign frame    = s_axis_tdata[63:48];
  assign since    = now_q - prev_beat_q;
  assign elapsed  = now_q - anchor_q;
  assign thr_lhs  = ebd_pkg::THR_W'(energy_q) * ebd_pkg::THR_W'(ebd_pkg::THR_LHS_K);
  assign thr_rhs  = ebd_pkg::THR_W'(ring_total) * ebd_pkg::THR_W'(ebd_pkg::THR_RHS_K)
                  + ebd_pkg::THR_W'(ebd_pkg::THR_RHS_C);
  assign beat_now = (thr_lhs > thr_rhs)
                  && (!prev_valid_q || since > ebd_pkg::TIME_W'(ebd_pkg::REFRACT_MS));
  assign tempo_ok = beat_now && prev_valid_q
                  && since > ebd_pkg::TIME_W'(ebd_pkg::TEMPO_MIN_MS)
                  && since < ebd_pkg::TIME_W'(ebd_pkg::TEMPO_MAX_MS);
  assign sum_new   = tempo_sum_q + ebd_pkg::SUM_W'(div_rsp.quo[ebd_pkg::BPM_W-1:0]);
  assign sum_round = {1'b0, sum_new} + (ebd_pkg::SUM_W+1)'(ebd_pkg::AVG_LEN / 2);
  assign env_scale = ebd_pkg::DT_W'(ebd_pkg::ENV_SPAN) - dt_q;
  // floor(decay / 300) sits at bit ENV_RECIP_SH of the reciprocal product
  assign decay_scaled = ebd_pkg::SCALED_W'(decay_q)
                      * ebd_pkg::SCALED_W'(ebd_pkg::ENV_RECIP);
  assign tracking  = sync_q && (latched_q >= ebd_pkg::IVL_W'(ebd_pkg::REFRACT_MS));

  always_comb begin
    state_d        = state_q;
    energy_d       = energy_q;
    now_d          = now_q;
    dt_d           = dt_q;
    beat_d         = beat_q;
    since_d        = since_q;
    prev_beat_d    = prev_beat_q;
    prev_valid_d   = prev_valid_q;
    tempo_sum_d    = tempo_sum_q;
    tempo_tally_d  = tempo_tally_q;
    tempo_avg_d    = tempo_avg_q;
    latched_d      = latched_q;
    env_d          = env_q;
    decay_d        = decay_q;
    anchor_d       = anchor_q;
    phase_d        = phase_q;
    m_valid_d      = m_valid_q && !m_axis_tready;
    m_data_d       = m_data_q;
    ring_commit    = 1'b0;
    div_req.start  = 1'b0;
    div_req.num    = '0;
    div_req.den    = '0;
    s_axis_tready  = 1'b0;

    unique case (state_q)
      ebd_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          energy_d = s_axis_tdata[15:0];
          now_d    = s_axis_tdata[47:16];
          if (frame == '0 || frame > ebd_pkg::FRAME_W'(ebd_pkg::DT_MAX)) begin
            dt_d = ebd_pkg::DT_W'(ebd_pkg::DT_DEFAULT);
          end else begin
            dt_d = frame[ebd_pkg::DT_W-1:0];
          end
          state_d = ebd_pkg::S_EVAL;
        end
      end

      ebd_pkg::S_EVAL: begin
        ring_commit = 1'b1;
        beat_d      = beat_now;
        since_d     = since[ebd_pkg::IVL_W-1:0];
        if (beat_now) begin
          prev_beat_d  = now_q;
          prev_valid_d = 1'b1;
        end
        if (tempo_ok) begin
          // round(960000 / interval)
          div_req.start = 1'b1;
          div_req.num   = ebd_pkg::DIV_NW'(ebd_pkg::TEMPO_NUM)
                        + ebd_pkg::DIV_NW'(since[ebd_pkg::IVL_W-1:1]);
          div_req.den   = since[ebd_pkg::DIV_DW-1:0];
          state_d       = ebd_pkg::S_TEMPO_WAIT;
        end else begin
          state_d = ebd_pkg::S_ENV;
        end
      end

      ebd_pkg::S_TEMPO_WAIT: begin
        if (div_rsp.done) begin
          if (tempo_tally_q == ebd_pkg::TALLY_W'(ebd_pkg::AVG_LEN - 1)) begin
            tempo_avg_d   = sum_round[ebd_pkg::SUM_W-1:ebd_pkg::TALLY_W];
            tempo_sum_d   = '0;
            tempo_tally_d = '0;
            latched_d     = since_q;
          end else begin
            tempo_sum_d   = sum_new;
            tempo_tally_d = tempo_tally_q + 1'b1;
          end
          state_d = ebd_pkg::S_ENV;
        end
      end

      ebd_pkg::S_ENV: begin
        if (beat_q) begin
          env_d   = ebd_pkg::LEVEL_W'(ebd_pkg::UNITY);
          state_d = ebd_pkg::S_PHASE;
        end else if (dt_q >= ebd_pkg::DT_W'(ebd_pkg::ENV_SPAN)) begin
          env_d   = '0;
          state_d = ebd_pkg::S_PHASE;
        end else begin
          // Decay: floor(env * (300 - dt) / 300), the product first
          decay_d = ebd_pkg::DECAY_W'(env_q) * ebd_pkg::DECAY_W'(env_scale);
          state_d = ebd_pkg::S_ENV_WAIT;
        end
      end

      ebd_pkg::S_ENV_WAIT: begin
        env_d   = decay_scaled[ebd_pkg::ENV_RECIP_SH +: ebd_pkg::LEVEL_W];
        state_d = ebd_pkg::S_PHASE;
      end

      ebd_pkg::S_PHASE: begin
        state_d = ebd_pkg::S_DONE;
        if (!tracking) begin
          phase_d = '0;
        end else if (beat_q) begin
          anchor_d = now_q;
          phase_d  = '0;
        end else if (elapsed >= ebd_pkg::TIME_W'(latched_q)) begin
          phase_d = ebd_pkg::PHASE_W'(ebd_pkg::UNITY);
        end else begin
          div_req.start = 1'b1;
          div_req.num   = {elapsed[ebd_pkg::IVL_W-1:0], {ebd_pkg::FRAC_W{1'b0}}};
          div_req.den   = latched_q;
          state_d       = ebd_pkg::S_PHASE_WAIT;
        end
      end

      ebd_pkg::S_PHASE_WAIT: begin
        if (div_rsp.done) begin
          phase_d = div_rsp.quo[ebd_pkg::PHASE_W-1:0];
          state_d = ebd_pkg::S_DONE;
        end
      end

      ebd_pkg::S_DONE: begin
        // Hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = ebd_pkg::OUT_DATA_W'({phase_q, env_q, tempo_avg_q, beat_q});
          state_d   = ebd_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ebd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ebd_pkg::S_IDLE;
      prev_beat_q   <= '0;
      prev_valid_q  <= 1'b0;
      tempo_sum_q   <= '0;
      tempo_tally_q <= '0;
      tempo_avg_q   <= '0;
      latched_q     <= '0;
      env_q         <= '0;
      anchor_q      <= '0;
      sync_q        <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      prev_beat_q   <= prev_beat_d;
      prev_valid_q  <= prev_valid_d;
      tempo_sum_q   <= tempo_sum_d;
      tempo_tally_q <= tempo_tally_d;
      tempo_avg_q   <= tempo_avg_d;
      latched_q     <= latched_d;
      env_q         <= env_d;
      anchor_q      <= anchor_d;
      m_valid_q     <= m_valid_d;
      if (cfg_wr) begin
        sync_q <= pwdata[0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    energy_q <= energy_d;
    now_q    <= now_d;
    dt_q     <= dt_d;
    beat_q   <= beat_d;
    since_q  <= since_d;
    decay_q  <= decay_d;
    phase_q  <= phase_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

### verif/energy_beat_detector_tb.sv
// Self-checking testbench for energy_beat_detector: frame stream in, beat report stream out.
// Predicts beat, tempo, envelope and phase per frame; depends on ebd_pkg and the block.
`timescale 1ns / 100ps

module energy_beat_detector_tb;
  import ebd_pkg::*;

  localparam logic [PADDR_W-1:0] SYNC_ADDR  = PADDR_W'(4 * REG_SYNC_ENABLE);
  // one register past the end of the map; writes there must be ignored
  localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;

  // beat lands in bit 0, so it goes last in the packed struct
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [LEVEL_W-1:0] level;
    logic [BPM_W-1:0]   bpm;
    logic               beat;
  } beat_report_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [PADDR_W-1:0]    paddr   = '0;
  logic [PDATA_W-1:0]    pwdata  = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  energy_beat_detector uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("energy_beat_detector: mismatch");
    $finish;
  end

  // Frames waiting to go out, and beat reports waiting to come back
  logic [IN_DATA_W-1:0] frame_q[$];
  beat_report_t         report_q[$];
  int unsigned          queued_cnt = 0;
  int unsigned          got_cnt    = 0;
  int unsigned          err_cnt    = 0;

  // Detector state as the block should hold it
  logic [ENERGY_W-1:0] hist [HISTORY_DEPTH];
  logic [RING_AW-1:0]  hist_pos        = '0;
  int unsigned         hist_sum        = 0;
  logic [TIME_W-1:0]   last_beat_ms    = '0;
  logic                last_beat_valid = 1'b0;
  int unsigned         tempo_acc       = 0;
  int unsigned         tempo_cnt       = 0;
  int unsigned         tempo_mean      = 0;
  int unsigned         lock_ivl        = 0;
  int unsigned         env_level       = 0;
  logic [TIME_W-1:0]   anchor_ms       = '0;
  logic                sync_cfg        = 1'b0;

  initial begin
    foreach (hist[i]) hist[i] = '0;
  end

  function automatic beat_report_t score_frame(input logic [ENERGY_W-1:0] energy,
                                               input logic [TIME_W-1:0] now,
                                               input logic [FRAME_W-1:0] fms);
    int unsigned       dt;
    logic [TIME_W-1:0] since;
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       lhs;
    logic [63:0]       rhs;
    int unsigned       phase;
    beat_report_t      r;
    r     = '0;
    phase = 0;
    dt    = (fms == 0 || fms > DT_MAX) ? DT_DEFAULT : fms;

    hist_sum       = hist_sum - hist[hist_pos] + energy;
    hist[hist_pos] = energy;
    hist_pos       = hist_pos + 1'b1;

    lhs   = 64'(energy) * THR_LHS_K;
    rhs   = 64'(hist_sum) * THR_RHS_K + THR_RHS_C;
    since = now - last_beat_ms;
    if (lhs > rhs && (!last_beat_valid || since > REFRACT_MS)) begin
      r.beat = 1'b1;
      if (last_beat_valid && since > TEMPO_MIN_MS && since < TEMPO_MAX_MS) begin
        tempo_acc += (TEMPO_NUM + since / 2) / since;
        tempo_cnt++;
        if (tempo_cnt >= AVG_LEN) begin
          tempo_mean = (tempo_acc + AVG_LEN / 2) / AVG_LEN;
          tempo_acc  = 0;
          tempo_cnt  = 0;
          lock_ivl   = since;
        end
      end
      last_beat_ms    = now;
      last_beat_valid = 1'b1;
    end

    if (r.beat) begin
      env_level = UNITY;
    end else if (dt >= ENV_SPAN) begin
      env_level = 0;
    end else begin
      env_level = (env_level * (ENV_SPAN - dt)) / ENV_SPAN;
    end

    if (sync_cfg && lock_ivl >= REFRACT_MS) begin
      if (r.beat) begin
        anchor_ms = now;
      end else begin
        elapsed = now - anchor_ms;
        if (elapsed >= lock_ivl) begin
          phase = UNITY;
        end else begin
          phase = int'((64'(elapsed) * UNITY) / lock_ivl);
        end
      end
    end

    r.bpm   = tempo_mean[BPM_W-1:0];
    r.level = env_level[LEVEL_W-1:0];
    r.phase = phase[PHASE_W-1:0];
    return r;
  endfunction

  // Frame driver: bursts of random length, random gaps between them
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        report_q.push_back(score_frame(s_axis_tdata[15:0], s_axis_tdata[47:16],
                                       s_axis_tdata[63:48]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || frame_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          s_axis_tdata  <= frame_q.pop_front();
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
      err_cnt++;
    end
  endtask

  // Report monitor; the receiver stalls on segments of random mode, plus long holds
  int rx_mode    = 0;
  int seg_left   = 0;
  int hold_left  = 0;
  int hold_mark  = 200;
  beat_report_t seen_rep;
  beat_report_t want_rep;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen_rep = beat_report_t'(m_axis_tdata[OUT_USED_W-1:0]);
        if (report_q.size() == 0) begin
          $display("%0t: unexpected report, got %h", $time, seen_rep);
          err_cnt++;
        end else begin
          want_rep = report_q.pop_front();
          check_field("beat", 32'(want_rep.beat), 32'(seen_rep.beat));
          check_field("bpm_x16", 32'(want_rep.bpm), 32'(seen_rep.bpm));
          check_field("beat_level", 32'(want_rep.level), 32'(seen_rep.level));
          check_field("beat_phase", 32'(want_rep.phase), 32'(seen_rep.phase));
        end
        got_cnt++;
      end
      if (hold_left == 0 && got_cnt == hold_mark) begin
        hold_left = HOLD_CYCLES;
        hold_mark += 800;
      end
      if (seg_left == 0) begin
        rx_mode  = $urandom_range(0, 2);
        seg_left = $urandom_range(10, 150);
      end else begin
        seg_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_mode == 0) begin
        m_axis_tready <= 1'b1;
      end else if (rx_mode == 1) begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) == 0);
      end
    end
  end

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == SYNC_ADDR) sync_cfg = data[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [PADDR_W-1:0] addr);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== PDATA_W'(sync_cfg)) begin
      $display("%0t: sync_enable readback expected %0d, got %h", $time, sync_cfg, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_frame(input logic [ENERGY_W-1:0] energy, input logic [TIME_W-1:0] now,
                            input logic [FRAME_W-1:0] fms);
    frame_q.push_back({fms, now, energy});
    queued_cnt++;
  endtask

  task automatic wait_drained();
    while (got_cnt != queued_cnt) @(posedge clk_i);
  endtask

  // Rhythmic material: quiet floor with periodic peaks, some noise and broken timing
  task automatic gen_song(input int n, input logic [TIME_W-1:0] t0);
    logic [TIME_W-1:0]   now;
    logic [TIME_W-1:0]   next_peak;
    logic [ENERGY_W-1:0] energy;
    logic [FRAME_W-1:0]  fms;
    int                  period;
    int                  dt;
    int                  roll;
    now       = t0;
    period    = $urandom_range(260, 1900);
    next_peak = now + period;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 199) == 0) period = $urandom_range(260, 1900);
      dt  = $urandom_range(10, 60);
      now = now + dt;
      fms = FRAME_W'(dt);
      if ($signed(now - next_peak) >= 0) begin
        energy    = ENERGY_W'($urandom_range(20000, 65535));
        next_peak = now + period;
      end else begin
        energy = ENERGY_W'($urandom_range(0, 3000));
      end
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        energy = ENERGY_W'($urandom_range(0, 65535));
      end else if (roll < 10) begin
        case ($urandom_range(0, 3))
          0:       fms = '0;
          1:       fms = FRAME_W'($urandom_range(DT_MAX + 1, 65535));
          2:       fms = FRAME_W'($urandom_range(ENV_SPAN, DT_MAX));
          default: fms = FRAME_W'($urandom_range(0, 65535));
        endcase
      end else if (roll < 12) begin
        // jump the clock anywhere, then resume the rhythm from there
        now       = $urandom();
        next_peak = now + period;
      end
      push_frame(energy, now, fms);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (rst_ni);
    @(posedge clk_i);

    // Directed: first beat with no history, refractory, tempo window edges,
    // bad frame times, envelope cut, clock wrap, then enough beats to lock
    push_frame(16'd0,     32'd0,         16'd0);
    push_frame(16'hFFFF,  32'd100,       16'd1000);
    push_frame(16'hFFFF,  32'd150,       16'd1001);
    push_frame(16'd1200,  32'd170,       16'd20);
    push_frame(16'hFFFF,  32'd400,       16'hFFFF);
    push_frame(16'hFFFF,  32'd650,       16'd299);
    push_frame(16'd0,     32'd700,       16'd300);
    push_frame(16'hFFFF,  32'd2650,      16'd1);
    push_frame(16'd30000, 32'd2900,      16'd250);
    push_frame(16'hFFFF,  32'hFFFF_FFF0, 16'd999);
    push_frame(16'd0,     32'hFFFF_FFFF, 16'd15);
    push_frame(16'hFFFF,  32'h0000_0200, 16'd50);
    for (int k = 1; k <= 7; k++) begin
      push_frame(16'hFFFF, 32'h0000_0200 + 500 * k, 16'd50);
    end
    push_frame(16'h5555,  32'hAAAA_AAAA, 16'hAAAA);
    push_frame(16'hAAAA,  32'h5555_5555, 16'h5555);
    wait_drained();

    apb_read_check(SYNC_ADDR);
    apb_write(SYNC_ADDR, 32'hFFFF_FFFF);
    apb_write(SPARE_ADDR, 32'h0);
    apb_read_check(SYNC_ADDR);
    gen_song(600, $urandom());
    wait_drained();

    apb_write(SYNC_ADDR, 32'hFFFF_FFFE);
    apb_read_check(SYNC_ADDR);
    gen_song(300, $urandom());
    wait_drained();

    apb_write(SYNC_ADDR, 32'h0000_0001);
    apb_write(SPARE_ADDR, 32'hFFFF_FFFF);
    apb_read_check(SYNC_ADDR);
    gen_song(700, 32'hFFFF_FFFF - 12000);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && report_q.size() == 0) begin
      $display("energy_beat_detector: match");
    end else begin
      $display("energy_beat_detector: mismatch");
    end
    $finish;
  end

endmodule
